FILE: rtl/core/fdc_pkg.sv
// shared types, constants and crc function for the framed packet deframer
package fdc_pkg;

    localparam int unsigned FDC_MAX_FRAME = 4096;

    localparam logic [7:0]  SOF_BYTE       = 8'hAA;
    localparam logic [7:0]  EOF_BYTE       = 8'h55;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_ALT_OFFSET = 16'h0100;

    localparam int unsigned MIN_FRAME_LEN  = 22;
    localparam int unsigned ADDR_LAST      = 8;
    localparam int unsigned BODY_LEN_LAST  = 12;
    localparam int unsigned CMD_LAST       = 14;
    localparam int unsigned STATUS_POS     = 15;
    localparam int unsigned DATA_LEN_LAST  = 19;
    localparam int unsigned PAYLOAD_START  = 20;
    localparam int unsigned BODY_OFFSET    = 13;
    localparam int unsigned LEN_OVERHEAD   = 16;
    localparam int unsigned CRC_START      = 3;

    localparam int unsigned RES_FIELD_W    = 130;
    localparam int unsigned OUT_TDATA_W    = 136;
    localparam int unsigned OUT_PAD_W      = OUT_TDATA_W - RES_FIELD_W;

    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_FRAME_ERR = 2'd1,
        VERDICT_CRC_ERR   = 2'd2
    } t_verdict;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        t_verdict    verdict;
        logic [63:0] frame_address;
        logic [15:0] command;
        logic [7:0]  status_field;
        logic [31:0] declared_data_length;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/fdc_in_stage.sv
// input register for received bytes
module fdc_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_take,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
endmodule

FILE: rtl/core/fdc_parser.sv
// frame field capture, crc accumulation and end-of-buffer verdict
module fdc_parser #(
    parameter int unsigned MAX_FRAME = fdc_pkg::FDC_MAX_FRAME
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_res_valid,
    output fdc_pkg::t_result o_res
);
    import fdc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] r_byte_count, n_byte_count, u_byte_count;
    logic [15:0]   r_crc, n_crc, u_crc;
    logic [7:0]    r_tail [3];
    logic [7:0]    n_tail [3];
    logic [7:0]    u_tail [3];
    logic [7:0]    r_first, n_first, u_first;
    logic [63:0]   r_addr, n_addr, u_addr;
    logic [31:0]   r_body_len, n_body_len, u_body_len;
    logic [15:0]   r_cmd, n_cmd, u_cmd;
    logic [7:0]    r_status, n_status, u_status;
    logic [31:0]   r_data_len, n_data_len, u_data_len;
    logic          r_overflow, n_overflow, u_overflow;

    logic          payload;
    logic          frame_err;
    logic          crc_err;
    logic [15:0]   rx_crc;
    t_verdict      verdict;

    // per-byte update of frame state
    always_comb begin
        u_byte_count = r_byte_count;
        u_crc        = r_crc;
        u_tail       = r_tail;
        u_first      = r_first;
        u_addr       = r_addr;
        u_body_len   = r_body_len;
        u_cmd        = r_cmd;
        u_status     = r_status;
        u_data_len   = r_data_len;
        u_overflow   = r_overflow;
        payload      = 1'b0;
        if (r_byte_count >= CW'(MAX_FRAME)) begin
            u_overflow = 1'b1;
        end else begin
            if (r_byte_count == '0) begin
                u_first = i_byte;
            end else if (r_byte_count <= CW'(ADDR_LAST)) begin
                u_addr = {r_addr[55:0], i_byte};
            end else if (r_byte_count <= CW'(BODY_LEN_LAST)) begin
                u_body_len = {r_body_len[23:0], i_byte};
            end else if (r_byte_count <= CW'(CMD_LAST)) begin
                u_cmd = {r_cmd[7:0], i_byte};
            end else if (r_byte_count == CW'(STATUS_POS)) begin
                u_status = i_byte;
            end else if (r_byte_count <= CW'(DATA_LEN_LAST)) begin
                u_data_len = {r_data_len[23:0], i_byte};
            end else if (33'(r_byte_count) < ({1'b0, r_body_len} + 33'(BODY_OFFSET))) begin
                payload = 1'b1;
            end
            if (r_byte_count >= CW'(CRC_START)) begin
                u_crc = crc16_byte(r_crc, r_tail[2]);
            end
            u_tail[2]    = r_tail[1];
            u_tail[1]    = r_tail[0];
            u_tail[0]    = i_byte;
            u_byte_count = r_byte_count + CW'(1);
        end
    end

    // verdict from the updated state
    always_comb begin
        rx_crc    = {u_tail[2], u_tail[1]};
        frame_err = (u_byte_count <= CW'(MIN_FRAME_LEN)) || u_overflow
                 || (u_first != SOF_BYTE) || (u_tail[0] != EOF_BYTE)
                 || (({1'b0, u_body_len} + 33'(LEN_OVERHEAD)) != 33'(u_byte_count));
        crc_err   = (u_crc != rx_crc) && (u_crc != (rx_crc + CRC_ALT_OFFSET));
        if (frame_err) begin
            verdict = VERDICT_FRAME_ERR;
        end else if (crc_err) begin
            verdict = VERDICT_CRC_ERR;
        end else begin
            verdict = VERDICT_OK;
        end
    end

    // next state: hold, advance, or clear after a verdict
    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_tail       = r_tail;
        n_first      = r_first;
        n_addr       = r_addr;
        n_body_len   = r_body_len;
        n_cmd        = r_cmd;
        n_status     = r_status;
        n_data_len   = r_data_len;
        n_overflow   = r_overflow;
        if (i_step && i_last) begin
            n_byte_count = '0;
            n_crc        = '0;
            n_tail       = '{default: 8'h00};
            n_first      = '0;
            n_addr       = '0;
            n_body_len   = '0;
            n_cmd        = '0;
            n_status     = '0;
            n_data_len   = '0;
            n_overflow   = 1'b0;
        end else if (i_step) begin
            n_byte_count = u_byte_count;
            n_crc        = u_crc;
            n_tail       = u_tail;
            n_first      = u_first;
            n_addr       = u_addr;
            n_body_len   = u_body_len;
            n_cmd        = u_cmd;
            n_status     = u_status;
            n_data_len   = u_data_len;
            n_overflow   = u_overflow;
        end
    end

    // result selection
    always_comb begin
        o_res_valid = i_step && (i_last || payload);
        o_res       = '0;
        if (i_last) begin
            o_res.kind                 = KIND_VERDICT;
            o_res.verdict              = verdict;
            o_res.frame_address        = u_addr;
            o_res.command              = u_cmd;
            o_res.status_field         = u_status;
            o_res.declared_data_length = u_data_len;
        end else begin
            o_res.kind         = KIND_PAYLOAD;
            o_res.verdict      = VERDICT_OK;
            o_res.payload_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= '0;
            r_tail       <= '{default: 8'h00};
            r_first      <= '0;
            r_addr       <= '0;
            r_body_len   <= '0;
            r_cmd        <= '0;
            r_status     <= '0;
            r_data_len   <= '0;
            r_overflow   <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_tail       <= n_tail;
            r_first      <= n_first;
            r_addr       <= n_addr;
            r_body_len   <= n_body_len;
            r_cmd        <= n_cmd;
            r_status     <= n_status;
            r_data_len   <= n_data_len;
            r_overflow   <= n_overflow;
        end
    end

    a_clear_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_byte_count == '0) && !r_overflow && (r_crc == '0))
        else $error("frame state not cleared after verdict");

    a_overflow_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_byte_count == CW'(MAX_FRAME)))
        else $error("overflow flagged without saturated byte count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CW'(MAX_FRAME))
        else $error("byte count beyond frame limit");

    a_payload_not_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_last) |-> (r_byte_count >= CW'(PAYLOAD_START)))
        else $error("payload request raised inside header");
endmodule

FILE: rtl/core/fdc_out_stage.sv
// result register driving the output stream
module fdc_out_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  fdc_pkg::t_result                    i_res,
    output logic                                o_ready,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [fdc_pkg::OUT_TDATA_W-1:0]     o_tdata,
    output logic                                o_tuser
);
    import fdc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_res.kind;
    assign o_tdata  = {{OUT_PAD_W{1'b0}}, r_res.declared_data_length, r_res.status_field,
                       r_res.command, r_res.frame_address, r_res.verdict, r_res.payload_byte};
endmodule

FILE: rtl/core/frame_deframer_crc16.sv
// top level of the framed packet deframer with crc-16 check
//
// bytes of one received buffer enter on the s_axis channel, one per request,
// tlast on the final byte. the frame is start 0xaa, 8-byte address, 4-byte
// body length, 2-byte command, status byte, 4-byte data length, payload,
// 2-byte crc, end 0x55, all big-endian.
// m_axis carries results: tuser 0 is a payload byte, tuser 1 the verdict
// for the buffer (0 ok, 1 frame error, 2 crc error) with the header fields.
// non-payload bytes other than the last produce no result.
// throughput: one byte per cycle unless the receiver stalls. the input register,
// combinational field capture and crc update, and the result register form the
// path; a result is registered once its byte moves on from the input register.
// reset clears all frame state; the first byte after reset starts a frame.
// when the receiver stalls, the result register holds, the input register
// fills, and s_axis_tready drops until m_axis_tready returns.
module frame_deframer_crc16 #(
    parameter int unsigned MAX_FRAME = fdc_pkg::FDC_MAX_FRAME
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // rx_byte[7:0]
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // payload_byte[7:0], verdict[9:8], frame_address[73:10], command[89:74],
    // status_field[97:90], declared_data_length[129:98], zero fill
    output logic [fdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tuser   // kind
);
    import fdc_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_ready;
    logic       step;
    logic       res_valid;
    t_result    res;

    assign step = in_valid && out_ready;

    fdc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_take  (step),
        .o_ready (s_axis_tready),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_last  (in_last)
    );

    fdc_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .i_last      (in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fdc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_res    (res),
        .o_ready  (out_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");
endmodule

FILE: sim/tb_top.sv
// testbench for frame_deframer_crc16: framed byte stream stimulus with a self-checking scoreboard
`timescale 1ns / 100ps

module tb_top;
    import fdc_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned RANDOM_BYTES = 1200;

    typedef enum int {
        FAULT_NONE,
        FAULT_CRC_ALT,
        FAULT_CRC_WRAP,
        FAULT_CRC_BAD,
        FAULT_SOF,
        FAULT_EOF,
        FAULT_LEN
    } t_frame_fault;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } t_rx_req;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;  // rx_byte[7:0]
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // payload_byte[7:0], verdict[9:8], frame_address[73:10], command[89:74],
    // status_field[97:90], declared_data_length[129:98], zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;          // kind

    t_rx_req     rx_pending[$];
    t_result     results_due[$];
    int unsigned rx_wait = 0;
    int unsigned tx_wait = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;
    bit          calm_phase = 1'b0;

    // deframer state
    logic [12:0]      rx_count;
    logic [15:0]      crc_acc;
    logic [2:0][7:0]  tail;
    logic [7:0]       sof_seen;
    logic [63:0]      addr_acc;
    logic [31:0]      body_len_acc;
    logic [15:0]      cmd_acc;
    logic [7:0]       stat_acc;
    logic [31:0]      dlen_acc;
    logic             overflowed;

    frame_deframer_crc16 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[k]) ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic int unsigned gap_draw();
        return calm_phase ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic void clear_frame();
        rx_count     = '0;
        crc_acc      = '0;
        tail         = '0;
        sof_seen     = '0;
        addr_acc     = '0;
        body_len_acc = '0;
        cmd_acc      = '0;
        stat_acc     = '0;
        dlen_acc     = '0;
        overflowed   = 1'b0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic eob);
        logic        is_payload;
        logic [15:0] rx_crc;
        t_result     r;
        is_payload = 1'b0;
        if (rx_count >= FDC_MAX_FRAME) begin
            overflowed = 1'b1;
        end else begin
            if (rx_count == 0) begin
                sof_seen = b;
            end else if (rx_count <= ADDR_LAST) begin
                addr_acc = {addr_acc[55:0], b};
            end else if (rx_count <= BODY_LEN_LAST) begin
                body_len_acc = {body_len_acc[23:0], b};
            end else if (rx_count <= CMD_LAST) begin
                cmd_acc = {cmd_acc[7:0], b};
            end else if (rx_count == STATUS_POS) begin
                stat_acc = b;
            end else if (rx_count <= DATA_LEN_LAST) begin
                dlen_acc = {dlen_acc[23:0], b};
            end else if (33'(rx_count) < 33'(BODY_OFFSET) + 33'(body_len_acc)) begin
                is_payload = 1'b1;
            end
            if (rx_count >= CRC_START) begin
                crc_acc = crc_fold(crc_acc, tail[2]);
            end
            tail = {tail[1], tail[0], b};
            rx_count = rx_count + 13'd1;
        end

        r = '0;
        if (eob) begin
            rx_crc = {tail[2], tail[1]};
            r.kind = KIND_VERDICT;
            if (rx_count <= MIN_FRAME_LEN || overflowed || sof_seen != SOF_BYTE
                    || tail[0] != EOF_BYTE
                    || 33'(body_len_acc) + 33'(LEN_OVERHEAD) != 33'(rx_count)) begin
                r.verdict = VERDICT_FRAME_ERR;
            end else if (crc_acc != rx_crc && crc_acc != rx_crc + CRC_ALT_OFFSET) begin
                r.verdict = VERDICT_CRC_ERR;
            end else begin
                r.verdict = VERDICT_OK;
            end
            r.frame_address        = addr_acc;
            r.command              = cmd_acc;
            r.status_field         = stat_acc;
            r.declared_data_length = dlen_acc;
            results_due.insert(results_due.size(), r);
            clear_frame();
        end else if (is_payload) begin
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            results_due.insert(results_due.size(), r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                          input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    function automatic void queue_noise(input int unsigned len);
        for (int k = 0; k < len; k++) begin
            rx_pending.insert(rx_pending.size(), '{data: 8'($urandom), eob: (k == len - 1)});
        end
    endfunction

    // cut of 0 or of at least the frame size keeps the whole frame, otherwise the buffer ends after cut bytes
    function automatic void queue_frame(input int unsigned plen, input t_frame_fault fault,
                                        input int unsigned cut, input logic [63:0] addr,
                                        input logic [15:0] cmd, input logic [7:0] stat,
                                        input logic [31:0] dlen, input int fill);
        logic [7:0]  fb[$];
        logic [31:0] blen;
        logic [15:0] crc;
        int unsigned n;
        blen = plen + 7;
        if (fault == FAULT_LEN) begin
            blen = blen ^ (32'd1 << $urandom_range(0, 31));
        end
        fb.insert(fb.size(),
                  fault == FAULT_SOF ? SOF_BYTE ^ 8'($urandom_range(1, 255)) : SOF_BYTE);
        for (int k = 7; k >= 0; k--) fb.insert(fb.size(), addr[8*k +: 8]);
        for (int k = 3; k >= 0; k--) fb.insert(fb.size(), blen[8*k +: 8]);
        fb.insert(fb.size(), cmd[15:8]);
        fb.insert(fb.size(), cmd[7:0]);
        fb.insert(fb.size(), stat);
        for (int k = 3; k >= 0; k--) fb.insert(fb.size(), dlen[8*k +: 8]);
        for (int k = 0; k < plen; k++) begin
            fb.insert(fb.size(), fill < 0 ? 8'($urandom) : fill[7:0]);
        end
        // wrap case: reroll the two low data length bytes until the crc high byte is zero
        do begin
            if (fault == FAULT_CRC_WRAP) begin
                fb[18] = 8'($urandom);
                fb[19] = 8'($urandom);
            end
            crc = 16'h0000;
            foreach (fb[k]) crc = crc_fold(crc, fb[k]);
        end while (fault == FAULT_CRC_WRAP && crc[15:8] != 8'h00);
        if (fault == FAULT_CRC_ALT || fault == FAULT_CRC_WRAP) begin
            crc = crc - CRC_ALT_OFFSET;
        end else if (fault == FAULT_CRC_BAD) begin
            crc = crc + 16'($urandom_range(1, 16'hfeff));
        end
        fb.insert(fb.size(), crc[15:8]);
        fb.insert(fb.size(), crc[7:0]);
        fb.insert(fb.size(),
                  fault == FAULT_EOF ? EOF_BYTE ^ 8'($urandom_range(1, 255)) : EOF_BYTE);
        n = (cut != 0 && cut < fb.size()) ? cut : fb.size();
        for (int k = 0; k < n; k++) begin
            rx_pending.insert(rx_pending.size(), '{data: fb[k], eob: (k == n - 1)});
        end
    endfunction

    // driver: next request after its drawn gap
    always @(posedge i_clk) begin : drv
        t_rx_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            rx_wait       <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (rx_wait != 0) begin
                rx_wait       <= rx_wait - 1;
                s_axis_tvalid <= 1'b0;
            end else if (rx_pending.size() != 0) begin
                req = rx_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= req.data;
                s_axis_tlast  <= req.eob;
                rx_wait       <= gap_draw();
                if ($urandom_range(0, 39) == 0) begin
                    calm_phase <= !calm_phase;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: prediction, result check, receiver stalls and watchdog
    always @(posedge i_clk) begin : mon
        int unsigned stall;
        t_result     due;
        if (!i_rst_n) begin
            clear_frame();
            m_axis_tready <= 1'b0;
            tx_wait       <= 3;
            quiet_cycles  <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none actual tuser %0b tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    due = results_due.pop_front();
                    compare_field("kind", 64'(due.kind), 64'(m_axis_tuser));
                    compare_field("payload_byte", 64'(due.payload_byte),
                                  64'(m_axis_tdata[7:0]));
                    compare_field("verdict", 64'(due.verdict), 64'(m_axis_tdata[9:8]));
                    compare_field("frame_address", due.frame_address, m_axis_tdata[73:10]);
                    compare_field("command", 64'(due.command), 64'(m_axis_tdata[89:74]));
                    compare_field("status_field", 64'(due.status_field),
                                  64'(m_axis_tdata[97:90]));
                    compare_field("declared_data_length", 64'(due.declared_data_length),
                                  64'(m_axis_tdata[129:98]));
                end
                stall = gap_draw();
                m_axis_tready <= (stall == 0);
                tx_wait       <= stall;
            end else if (tx_wait != 0) begin
                tx_wait       <= tx_wait - 1;
                m_axis_tready <= (tx_wait == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end

            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stim
        int unsigned  base;
        int unsigned  plen;
        int unsigned  sel;
        int unsigned  cut;
        t_frame_fault fault;

        // directed buffers
        queue_noise(1);
        queue_frame(0, FAULT_NONE, 0, 64'h0, 16'h0, 8'h00, 32'h0, 0);
        queue_frame(3, FAULT_NONE, 0, '1, '1, '1, '1, 255);
        queue_frame(0, FAULT_NONE, 22, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                    $urandom, -1);
        queue_frame(10, FAULT_NONE, 25, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                    $urandom, -1);
        queue_frame(4, FAULT_CRC_ALT, 0, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                    4, -1);
        queue_frame(2, FAULT_CRC_WRAP, 0, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                    2, -1);
        queue_frame(5, FAULT_CRC_BAD, 0, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                    5, -1);
        queue_frame(1, FAULT_SOF, 0, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                    1, -1);
        queue_frame(1, FAULT_EOF, 0, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                    1, -1);
        queue_frame(6, FAULT_LEN, 0, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                    6, -1);

        // random buffers: noise and frames with or without faults
        base = rx_pending.size();
        while (rx_pending.size() - base < RANDOM_BYTES) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                queue_noise($urandom_range(1, 30));
            end else begin
                plen = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                    : $urandom_range(0, 24);
                sel = $urandom_range(0, 99);
                if (sel < 50)      fault = FAULT_NONE;
                else if (sel < 60) fault = FAULT_CRC_ALT;
                else if (sel < 63) fault = FAULT_CRC_WRAP;
                else if (sel < 72) fault = FAULT_CRC_BAD;
                else if (sel < 79) fault = FAULT_SOF;
                else if (sel < 86) fault = FAULT_EOF;
                else               fault = FAULT_LEN;
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, plen + 22) : 0;
                queue_frame(plen, fault, cut, {$urandom, $urandom}, 16'($urandom),
                            8'($urandom), $urandom, -1);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (rx_pending.size() != 0 || s_axis_tvalid || results_due.size() != 0);
        repeat (10) @(negedge i_clk);

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
